>>> src/nearest_preceding_address_search_assert.svh
// Assertion macros used by the top level of the nearest preceding address search.
`ifndef NEAREST_PRECEDING_ADDRESS_SEARCH_ASSERT_SVH
`define NEAREST_PRECEDING_ADDRESS_SEARCH_ASSERT_SVH
`ifndef ASSERT_OFF
`define NPAS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NPAS_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg)
`define NPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/npas_pkg.sv
// Shared constants and control types of the nearest preceding address search.
package npas_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;
    localparam int unsigned ADDR_W              = 64;
    localparam int unsigned ENTRY_INDEX_W       = 10;
    localparam int unsigned ENTRY_COUNT_W       = 11;
    localparam int unsigned CFG_INDEX_W         = 2;

    localparam logic [ADDR_W-1:0] NO_DISTANCE = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_LOWEST_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT    = 2'd1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic load_wr;
        logic query_start;
        logic scan_step;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_status_t;

endpackage

>>> src/nearest_preceding_address_search.sv
// Top level of the nearest preceding address search: controller, datapath and checks.
// A load request writes one table slot. A query request
// scans slots 0 to entry_count-1 (capped at TABLE_DEPTH) through the single read
// port of the table memory, one slot per cycle. An exact hit ends the scan early,
// and a query below lowest_address scans no slot. A new request is accepted as
// soon as the previous one has finished, even while its result still waits in
// the output register. Configuration writes are always accepted.
module nearest_preceding_address_search #(
    parameter int unsigned TABLE_DEPTH = npas_pkg::TABLE_DEPTH_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   opcode,
    input  logic [npas_pkg::ENTRY_INDEX_W-1:0]     entry_index,
    input  logic [npas_pkg::ADDR_W-1:0]            entry_address,
    input  logic [npas_pkg::ADDR_W-1:0]            query_address,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   found,
    output logic [npas_pkg::ENTRY_INDEX_W-1:0]     match_index,
    output logic [npas_pkg::ADDR_W-1:0]            distance,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [npas_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [npas_pkg::ADDR_W-1:0]            cfg_data
);
    import npas_pkg::*;

    `include "nearest_preceding_address_search_assert.svh"

    ctl_cmd_t   cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    npas_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    npas_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .entry_index   (entry_index),
        .entry_address (entry_address),
        .query_address (query_address),
        .found         (found),
        .match_index   (match_index),
        .distance      (distance)
    );

    // A query keeps the block busy for at least the following cycle.
    `NPAS_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && (opcode == OP_QUERY), !in_ready, "query accepted but block still ready")
    // A miss reports zero index and zero distance.
    `NPAS_ASSERT_HOLDS(a_miss_zero, clk, rst_n, out_valid && !found, (match_index == '0) && (distance == '0), "miss result carries nonzero fields")
    // The datapath never scans while the controller is waiting for a request.
    `NPAS_ASSERT_HOLDS(a_idle_no_scan, clk, rst_n, in_ready, !cmd.scan_step && !cmd.out_load, "scan or result load while idle")

endmodule

>>> src/npas_ctrl.sv
// Controller state machine that sequences loads, table scans and result delivery.
module npas_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  npas_pkg::dp_status_t  status,
    output npas_pkg::ctl_cmd_t    cmd
);
    import npas_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        accept          = in_valid && in_ready;
        cmd.load_wr     = accept && (opcode == OP_LOAD);
        cmd.query_start = accept && (opcode == OP_QUERY);
        cmd.scan_step   = (state_reg == ST_SCAN);
        cmd.out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.query_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (cmd.out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/npas_dp.sv
// Datapath with the entry table memory, configuration registers, scan compare and result register.
module npas_dp #(
    parameter int unsigned TABLE_DEPTH = npas_pkg::TABLE_DEPTH_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  npas_pkg::ctl_cmd_t                     cmd,
    output npas_pkg::dp_status_t                   status,
    input  logic                                   cfg_valid,
    input  logic [npas_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [npas_pkg::ADDR_W-1:0]            cfg_data,
    input  logic [npas_pkg::ENTRY_INDEX_W-1:0]     entry_index,
    input  logic [npas_pkg::ADDR_W-1:0]            entry_address,
    input  logic [npas_pkg::ADDR_W-1:0]            query_address,
    output logic                                   found,
    output logic [npas_pkg::ENTRY_INDEX_W-1:0]     match_index,
    output logic [npas_pkg::ADDR_W-1:0]            distance
);
    import npas_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [ADDR_W-1:0]        entry_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]        rd_data_reg;

    logic [ADDR_W-1:0]        lowest_address_reg;
    logic [ADDR_W-1:0]        lowest_address_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic [ENTRY_COUNT_W-1:0] entry_count_next;

    logic [ADDR_W-1:0]        query_reg;
    logic [ADDR_W-1:0]        query_next;
    logic [CNT_W-1:0]         limit_reg;
    logic [CNT_W-1:0]         limit_next;
    logic [CNT_W-1:0]         scan_idx_reg;
    logic [CNT_W-1:0]         scan_idx_next;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic [IDX_W-1:0]         cmp_idx_next;
    logic                     cmp_valid_reg;
    logic                     cmp_valid_next;
    logic                     stop_reg;
    logic                     stop_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [IDX_W-1:0]         best_idx_reg;
    logic [IDX_W-1:0]         best_idx_next;
    logic [ADDR_W-1:0]        best_dist_reg;
    logic [ADDR_W-1:0]        best_dist_next;

    logic                     found_reg;
    logic                     found_next;
    logic [ENTRY_INDEX_W-1:0] match_index_reg;
    logic [ENTRY_INDEX_W-1:0] match_index_next;
    logic [ADDR_W-1:0]        distance_reg;
    logic [ADDR_W-1:0]        distance_next;

    logic                     wr_in_range;
    logic                     issue;
    logic                     entry_le;
    logic [ADDR_W-1:0]        diff;
    logic                     take;
    logic [CNT_W-1:0]         sat_count;

    always_comb
    begin
        wr_in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
        sat_count   = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ?
                      CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_reg);
        issue       = cmd.scan_step && !stop_reg && (scan_idx_reg != limit_reg);
        entry_le    = (rd_data_reg <= query_reg);
        diff        = query_reg - rd_data_reg;
        take        = cmp_valid_reg && !stop_reg && entry_le && (diff < best_dist_reg);

        status.scan_done = !cmp_valid_reg && (stop_reg || (scan_idx_reg == limit_reg));

        lowest_address_next = lowest_address_reg;
        entry_count_next    = entry_count_reg;
        if (cfg_valid && (cfg_index == REG_LOWEST_ADDRESS))
        begin
            lowest_address_next = cfg_data;
        end
        if (cfg_valid && (cfg_index == REG_ENTRY_COUNT))
        begin
            entry_count_next = cfg_data[ENTRY_COUNT_W-1:0];
        end

        query_next     = query_reg;
        limit_next     = limit_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = issue;
        stop_next      = stop_reg;
        hit_next       = hit_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;

        if (cmd.query_start)
        begin
            query_next     = query_address;
            limit_next     = (query_address < lowest_address_reg) ? '0 : sat_count;
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
            stop_next      = 1'b0;
            hit_next       = 1'b0;
            best_idx_next  = '0;
            best_dist_next = NO_DISTANCE;
        end
        else
        begin
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
                cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
            end
            if (take)
            begin
                hit_next       = 1'b1;
                best_idx_next  = cmp_idx_reg;
                best_dist_next = diff;
                stop_next      = (diff == '0);
            end
        end

        found_next       = found_reg;
        match_index_next = match_index_reg;
        distance_next    = distance_reg;
        if (cmd.out_load)
        begin
            found_next       = hit_reg;
            match_index_next = hit_reg ? ENTRY_INDEX_W'(best_idx_reg) : '0;
            distance_next    = hit_reg ? best_dist_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && wr_in_range)
        begin
            entry_mem[IDX_W'(entry_index)] <= entry_address;
        end
        if (issue)
        begin
            rd_data_reg <= entry_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_address_reg <= '0;
            entry_count_reg    <= '0;
            limit_reg          <= '0;
            scan_idx_reg       <= '0;
            cmp_valid_reg      <= 1'b0;
            stop_reg           <= 1'b0;
            hit_reg            <= 1'b0;
        end
        else
        begin
            lowest_address_reg <= lowest_address_next;
            entry_count_reg    <= entry_count_next;
            limit_reg          <= limit_next;
            scan_idx_reg       <= scan_idx_next;
            cmp_valid_reg      <= cmp_valid_next;
            stop_reg           <= stop_next;
            hit_reg            <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        query_reg       <= query_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_dist_reg   <= best_dist_next;
        found_reg       <= found_next;
        match_index_reg <= match_index_next;
        distance_reg    <= distance_next;
    end

    assign found       = found_reg;
    assign match_index = match_index_reg;
    assign distance    = distance_reg;

endmodule
